// ===== rtl/raycast_column_projection_macros.svh =====
// Assertion helpers shared by the RTL; every user has clk and rst_n in scope.
`ifndef RAYCAST_COLUMN_PROJECTION_MACROS_SVH
`define RAYCAST_COLUMN_PROJECTION_MACROS_SVH

// Check that cons holds in any cycle where ante holds.
`define RCP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcp_pkg.sv =====
package rcp_pkg;

  localparam int WH_W     = 12;
  localparam int DIST_W   = 32;
  localparam int FRACIN_W = 16;
  localparam int TEX_W    = 13;
  localparam int SLICE_W  = 18;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 12;
  localparam int STEP_W   = 29;
  localparam int START_W  = 28;
  localparam int TPROD_W  = TEX_W + FRACIN_W;

  localparam logic [WH_W-1:0]    WH_RESET  = 12'd480;
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
  localparam logic [START_W-1:0] START_MAX = '1;

  // Pipeline control for the divider stages: word valid and global advance.
  typedef struct packed {
    logic vld;
    logic adv;
  } pipe_ctl_t;

endpackage

// ===== rtl/rcp_div_pipe.sv =====
module rcp_div_pipe #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 32,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcp_pkg::pipe_ctl_t   ctl,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  input  logic [SB_W-1:0]      sb_in,
  output logic                 vld_out,
  output logic [NUM_W-1:0]     quo,
  output logic [SB_W-1:0]      sb_out
);

  // One restoring quotient bit per stage, MSB first.
  logic             vld_r  [NUM_W];
  logic [DEN_W-1:0] rem_r  [NUM_W];
  logic [NUM_W-1:0] nq_r   [NUM_W];
  logic [DEN_W-1:0] den_r  [NUM_W];
  logic [SB_W-1:0]  sb_r   [NUM_W];

  logic             src_vld [NUM_W];
  logic [DEN_W-1:0] src_rem [NUM_W];
  logic [NUM_W-1:0] src_nq  [NUM_W];
  logic [DEN_W-1:0] src_den [NUM_W];
  logic [SB_W-1:0]  src_sb  [NUM_W];

  logic [DEN_W-1:0] rem_nxt [NUM_W];
  logic [NUM_W-1:0] nq_nxt  [NUM_W];

  always_comb begin
    src_vld[0] = ctl.vld;
    src_rem[0] = '0;
    src_nq[0]  = num;
    src_den[0] = den;
    src_sb[0]  = sb_in;
    for (int k = 1; k < NUM_W; k++) begin
      src_vld[k] = vld_r[k-1];
      src_rem[k] = rem_r[k-1];
      src_nq[k]  = nq_r[k-1];
      src_den[k] = den_r[k-1];
      src_sb[k]  = sb_r[k-1];
    end
  end

  always_comb begin
    logic [DEN_W:0]   part;
    logic [DEN_W+1:0] diff;
    logic             ge;
    for (int k = 0; k < NUM_W; k++) begin
      part       = {src_rem[k], src_nq[k][NUM_W-1]};
      diff       = {1'b0, part} - {2'b00, src_den[k]};
      ge         = !diff[DEN_W+1];
      rem_nxt[k] = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      nq_nxt[k]  = {src_nq[k][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_W; k++) vld_r[k] <= 1'b0;
    end else if (ctl.adv) begin
      for (int k = 0; k < NUM_W; k++) vld_r[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < NUM_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
        den_r[k] <= src_den[k];
        sb_r[k]  <= src_sb[k];
      end
    end
  end

  assign vld_out = vld_r[NUM_W-1];
  assign quo     = nq_r[NUM_W-1];
  assign sb_out  = sb_r[NUM_W-1];

endmodule

// ===== rtl/raycast_column_projection.sv =====
// Wall column projection for a raycaster, one screen column per word.
// Input channel (in_valid/in_ready): wall distance, hit fraction, side and
// direction flags, texture size. Output channel (out_valid/out_ready):
// slice height, draw rows, texel column, texel step and start, texture valid.
// Configuration: cfg_we writes cfg_window_height in that cycle; write it
// only while no word is in flight.
// Throughput: one word per cycle, sustained while the output is not stalled.
// Pipeline: the input register, then two bit-per-stage restoring
// dividers: window height over distance (12 + FRAC_BITS stages) and
// texture height over slice height (13 + FRAC_BITS stages), with the
// clamp register between them, then the multiply and output registers;
// the input register loads on the accepting edge itself.
// Reset: window height returns to 480 and every stage valid clears.
// Stall: while out_valid is high and out_ready low, the whole pipeline
// holds and in_ready drops in the same cycle; nothing is lost or repeated.
`include "raycast_column_projection_macros.svh"

module raycast_column_projection #(
  parameter int FRAC_BITS           = 16,
  parameter int HEIGHT_LIMIT_FACTOR = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rcp_pkg::WH_W-1:0]          cfg_window_height,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rcp_pkg::DIST_W-1:0] in_wall_distance,
  input  logic [rcp_pkg::FRACIN_W-1:0]      in_hit_fraction,
  input  logic                              in_hit_side,
  input  logic                              in_dir_x_positive,
  input  logic                              in_dir_y_negative,
  input  logic [rcp_pkg::TEX_W-1:0]         in_texture_width,
  input  logic [rcp_pkg::TEX_W-1:0]         in_texture_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcp_pkg::SLICE_W-1:0]       out_slice_height,
  output logic [rcp_pkg::ROW_W-1:0]         out_draw_top,
  output logic [rcp_pkg::ROW_W-1:0]         out_draw_bottom,
  output logic [rcp_pkg::COL_W-1:0]         out_texel_column,
  output logic [rcp_pkg::STEP_W-1:0]        out_texel_step,
  output logic [rcp_pkg::START_W-1:0]       out_texel_start,
  output logic                              out_texture_valid
);

  localparam int WH_W    = rcp_pkg::WH_W;
  localparam int Q1_W    = WH_W + FRAC_BITS;
  localparam int LIM_W   = WH_W + $clog2(HEIGHT_LIMIT_FACTOR + 1);
  localparam int HALF_W  = LIM_W - 1;
  localparam int Q2_W    = rcp_pkg::TEX_W + FRAC_BITS;
  localparam int CMP_W   = (Q1_W > LIM_W) ? Q1_W : LIM_W;
  localparam int SX_W    = (Q2_W > rcp_pkg::STEP_W) ? Q2_W : rcp_pkg::STEP_W;
  localparam int PROD_W  = rcp_pkg::START_W + HALF_W;
  localparam int TPROD_W = rcp_pkg::TPROD_W;
  localparam logic [rcp_pkg::DIST_W-1:0] ONE_FX = rcp_pkg::DIST_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [WH_W-1:0]             wh;
    logic [LIM_W-1:0]            limit;
    logic [rcp_pkg::TEX_W-1:0]   tw;
    logic [rcp_pkg::TEX_W-1:0]   th;
    logic                        mir;
    logic [TPROD_W-1:0]          prod;
    logic                        tv;
  } sb1_t;

  typedef struct packed {
    logic [LIM_W-1:0]            lh;
    logic [rcp_pkg::ROW_W-1:0]   top;
    logic [rcp_pkg::ROW_W-1:0]   bottom;
    logic [rcp_pkg::COL_W-1:0]   col;
    logic [HALF_W-1:0]           off;
    logic                        tv;
  } sb2_t;

  // Global advance: the pipeline moves unless the output word is stalled.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Window height register.
  logic [WH_W-1:0] wh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r <= rcp_pkg::WH_RESET;
    end else if (cfg_we) begin
      wh_r <= cfg_window_height;
    end
  end

  // Input stage: clean up distance, form the texel column product.
  logic                        s0_vld_r;
  logic [Q1_W-1:0]             s0_num_r;
  logic [rcp_pkg::DIST_W-1:0]  s0_den_r;
  sb1_t                        s0_sb_r;
  sb1_t                        s0_sb_nxt;
  logic [rcp_pkg::DIST_W-1:0]  s0_den_nxt;

  always_comb begin
    s0_den_nxt     = (in_wall_distance <= 0) ? ONE_FX : in_wall_distance;
    s0_sb_nxt.wh    = wh_r;
    s0_sb_nxt.limit = LIM_W'(wh_r) * LIM_W'(HEIGHT_LIMIT_FACTOR);
    s0_sb_nxt.tw    = in_texture_width;
    s0_sb_nxt.th    = in_texture_height;
    s0_sb_nxt.mir   = (!in_hit_side && in_dir_x_positive) ||
                      (in_hit_side && in_dir_y_negative);
    s0_sb_nxt.prod  = TPROD_W'(in_texture_width) * TPROD_W'(in_hit_fraction);
    s0_sb_nxt.tv    = (in_texture_width != '0) && (in_texture_height != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r <= Q1_W'(wh_r) << FRAC_BITS;
      s0_den_r <= s0_den_nxt;
      s0_sb_r  <= s0_sb_nxt;
    end
  end

  // Slice height quotient: (window height << FRAC_BITS) / distance.
  rcp_pkg::pipe_ctl_t d1_ctl;
  logic               d1_vld;
  logic [Q1_W-1:0]    d1_quo;
  sb1_t               d1_sb;

  assign d1_ctl.vld = s0_vld_r;
  assign d1_ctl.adv = adv;

  rcp_div_pipe #(
    .NUM_W (Q1_W),
    .DEN_W (rcp_pkg::DIST_W),
    .SB_W  ($bits(sb1_t))
  ) u_div_height (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (d1_ctl),
    .num     (s0_num_r),
    .den     (s0_den_r),
    .sb_in   (s0_sb_r),
    .vld_out (d1_vld),
    .quo     (d1_quo),
    .sb_out  (d1_sb)
  );

  // Clamp stage: slice height, draw rows, texel column, start offset.
  logic                        s1_vld_r;
  logic [Q2_W-1:0]             s1_num_r;
  sb2_t                        s1_sb_r;
  sb2_t                        s1_sb_nxt;

  always_comb begin
    logic [LIM_W-1:0]          lh;
    logic [WH_W-2:0]           half_wh;
    logic [HALF_W-1:0]         half_lh;
    logic [HALF_W-1:0]         half_wh_x;
    logic                      hl_gt;
    logic [HALF_W:0]           bsum;
    logic [TPROD_W-1:0]        c_raw;
    logic [TPROD_W-1:0]        tw_x;
    logic [TPROD_W-1:0]        cm;

    if (CMP_W'(d1_quo) > CMP_W'(d1_sb.limit)) begin
      lh = d1_sb.limit;
    end else if (d1_quo == '0) begin
      lh = LIM_W'(1);
    end else begin
      lh = LIM_W'(d1_quo);
    end
    // Zero window height gives a zero limit: hold the slice at one row.
    if (lh == '0) begin
      lh = LIM_W'(1);
    end

    half_wh   = d1_sb.wh[WH_W-1:1];
    half_lh   = lh[LIM_W-1:1];
    half_wh_x = HALF_W'(half_wh);
    hl_gt     = half_lh > half_wh_x;
    bsum      = (HALF_W+1)'(half_lh) + (HALF_W+1)'(half_wh);

    s1_sb_nxt.lh  = lh;
    s1_sb_nxt.top = hl_gt ? '0 : rcp_pkg::ROW_W'(half_wh_x - half_lh);
    if (d1_sb.wh == '0) begin
      s1_sb_nxt.bottom = '0;
    end else if (bsum >= (HALF_W+1)'(d1_sb.wh)) begin
      s1_sb_nxt.bottom = d1_sb.wh - WH_W'(1);
    end else begin
      s1_sb_nxt.bottom = rcp_pkg::ROW_W'(bsum);
    end
    s1_sb_nxt.off = hl_gt ? (half_lh - half_wh_x) : '0;

    // Texel column, mirrored for the far-facing sides.
    c_raw = d1_sb.prod >> FRAC_BITS;
    tw_x  = TPROD_W'(d1_sb.tw);
    if (d1_sb.mir) begin
      cm = (c_raw >= tw_x) ? '0 : (tw_x - TPROD_W'(1) - c_raw);
    end else begin
      cm = (c_raw >= tw_x) ? (tw_x - TPROD_W'(1)) : c_raw;
    end
    s1_sb_nxt.col = (cm > TPROD_W'(rcp_pkg::COL_MAX)) ? rcp_pkg::COL_MAX
                                                     : rcp_pkg::COL_W'(cm);
    s1_sb_nxt.tv  = d1_sb.tv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num_r <= Q2_W'(d1_sb.th) << FRAC_BITS;
      s1_sb_r  <= s1_sb_nxt;
    end
  end

  // Texel step quotient: (texture height << FRAC_BITS) / slice height.
  rcp_pkg::pipe_ctl_t d2_ctl;
  logic               d2_vld;
  logic [Q2_W-1:0]    d2_quo;
  sb2_t               d2_sb;

  assign d2_ctl.vld = s1_vld_r;
  assign d2_ctl.adv = adv;

  rcp_div_pipe #(
    .NUM_W (Q2_W),
    .DEN_W (LIM_W),
    .SB_W  ($bits(sb2_t))
  ) u_div_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (d2_ctl),
    .num     (s1_num_r),
    .den     (s1_sb_r.lh),
    .sb_in   (s1_sb_r),
    .vld_out (d2_vld),
    .quo     (d2_quo),
    .sb_out  (d2_sb)
  );

  // Multiply stage: start = offset * step, saturation flags.
  logic                          s2_vld_r;
  logic [PROD_W-1:0]             s2_prod_r;
  logic [rcp_pkg::STEP_W-1:0]    s2_step_r;
  logic                          s2_big_r;
  logic                          s2_offnz_r;
  sb2_t                          s2_sb_r;
  logic [SX_W-1:0]               stepx;
  logic [rcp_pkg::STEP_W-1:0]    step_sat;

  assign stepx    = SX_W'(d2_quo);
  assign step_sat = (stepx > SX_W'(rcp_pkg::STEP_MAX)) ? rcp_pkg::STEP_MAX
                                                      : rcp_pkg::STEP_W'(stepx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r  <= PROD_W'(rcp_pkg::START_W'(stepx)) * PROD_W'(d2_sb.off);
      s2_step_r  <= step_sat;
      s2_big_r   <= (stepx >> rcp_pkg::START_W) != '0;
      s2_offnz_r <= d2_sb.off != '0;
      s2_sb_r    <= d2_sb;
    end
  end

  // Output register.
  logic [rcp_pkg::START_W-1:0] start_nxt;

  always_comb begin
    if (!s2_offnz_r) begin
      start_nxt = '0;
    end else if (s2_big_r || (s2_prod_r > PROD_W'(rcp_pkg::START_MAX))) begin
      start_nxt = rcp_pkg::START_MAX;
    end else begin
      start_nxt = rcp_pkg::START_W'(s2_prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slice_height  <= rcp_pkg::SLICE_W'(s2_sb_r.lh);
      out_draw_top      <= s2_sb_r.top;
      out_draw_bottom   <= s2_sb_r.bottom;
      out_texel_column  <= s2_sb_r.tv ? s2_sb_r.col : '0;
      out_texel_step    <= s2_sb_r.tv ? s2_step_r : '0;
      out_texel_start   <= s2_sb_r.tv ? start_nxt : '0;
      out_texture_valid <= s2_sb_r.tv;
    end
  end

  `RCP_ASSERT_IMPLIES(a_rows_ordered, out_valid, out_draw_top <= out_draw_bottom, "draw rows out of order")
  `RCP_ASSERT_IMPLIES(a_no_tex_zero, out_valid && !out_texture_valid, out_texel_step == '0 && out_texel_start == '0 && out_texel_column == '0, "mapping not cleared without texture")
  `RCP_ASSERT_IMPLIES(a_step_den_nz, s1_vld_r, s1_sb_r.lh != '0, "zero divisor into step divider")
  `RCP_ASSERT_NEXT(a_drain, out_valid && out_ready && !s2_vld_r, !out_valid, "output word repeated")

endmodule
